### src/fbc_pkg.sv
// Shared constants for the frustum box cull block.
package fbc_pkg;

	localparam int NUM_PLANES_DEF = 6;
	localparam int COORD_BITS_DEF = 16;

	localparam int PLANE_REGS = 6;
	localparam int MASK_W     = 6;
	localparam int NORM_W     = 16;
	localparam int HALF_W     = 15;
	localparam int FRAC_BITS  = 14;
	localparam int NEAR_W     = 18;
	localparam int NEAR_MAX   = 262143;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;
	localparam int REG_IDX_W  = 3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_PLANE_ENABLE = 3'd6;
	localparam logic [MASK_W-1:0]    ENABLE_RESET     = 6'd63;

	// action codes
	localparam logic ACT_STRADDLE = 1'b0;
	localparam logic ACT_NEAR     = 1'b1;

endpackage

### src/frustum_box_cull.sv
// Frustum box cull: pipelined box versus plane-set test with APB plane registers.
//
// A box (center, half sizes, plane mask, action) is taken at a rising edge where
// start is high and busy is low. busy stays low: the pipeline takes one beat per
// clock with no bubbles, so throughput is one box per cycle.
// Each beat gives exactly one result, shown for one cycle on visible,
// straddle_mask and near_distance with done high. done is the valid bit of the
// reduce register; a box passes the stages register, multiply, sum, compare
// and reduce in that order. The result port cannot be stalled; the receiver
// must take done when it comes.
// Straddle mode reports the mask of tested planes a visible box crosses; near mode
// always tests the near plane and reports max(dist - extent, 0), saturated.
// Plane coefficients and the enable mask are written over the APB port,
// register i at byte address 8*i; they are read live by the pipeline, so the user
// must write them only while no box is in flight; the block does not enforce this.
// Reset clears all pipeline valid bits and all plane registers and sets the
// enable mask to all ones; results in flight at reset are dropped.
module frustum_box_cull
	import fbc_pkg::*;
#(
	parameter int NUM_PLANES = NUM_PLANES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [CFG_ADDR_W-1:0]        paddr,
	input  logic [CFG_DATA_W-1:0]        pwdata,
	output logic [CFG_DATA_W-1:0]        prdata,
	output logic                         pready,
	// box command
	input  logic                         start,
	output logic                         busy,
	input  logic                         action,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic signed [COORD_BITS-1:0] center_z,
	input  logic [HALF_W-1:0]            half_x,
	input  logic [HALF_W-1:0]            half_y,
	input  logic [HALF_W-1:0]            half_z,
	input  logic [MASK_W-1:0]            plane_mask,
	// result
	output logic                         done,
	output logic                         visible,
	output logic [MASK_W-1:0]            straddle_mask,
	output logic [NEAR_W-1:0]            near_distance
);

	// planes beyond the register set get no lane and are never tested
	localparam int LANES  = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;
	localparam int PROD_W = NORM_W + COORD_BITS;
	localparam int APRD_W = NORM_W + HALF_W;
	localparam int DOT_W  = PROD_W + 2;
	localparam int ADOT_W = APRD_W + 2;
	localparam int SDOT_W = DOT_W - FRAC_BITS;
	localparam int EXT_W  = ADOT_W - FRAC_BITS;
	localparam int CMP_W  = ((SDOT_W > EXT_W) ? SDOT_W : EXT_W) + 2;

	// ---------------- configuration registers ----------------
	logic [CFG_DATA_W-1:0] plane_q [PLANE_REGS];
	logic [MASK_W-1:0]     enable_q;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < PLANE_REGS; r++) plane_q[r] <= '0;
			enable_q <= ENABLE_RESET;
		end else if (cfg_wr) begin
			if (reg_idx < REG_IDX_W'(PLANE_REGS)) begin
				plane_q[reg_idx] <= pwdata;
			end else if (reg_idx == REG_PLANE_ENABLE) begin
				enable_q <= pwdata[MASK_W-1:0];
			end
		end
	end

	always_comb begin
		if (reg_idx < REG_IDX_W'(PLANE_REGS)) begin
			prdata = plane_q[reg_idx];
		end else if (reg_idx == REG_PLANE_ENABLE) begin
			prdata = CFG_DATA_W'(enable_q);
		end else begin
			prdata = '0;
		end
	end

	assign busy = 1'b0;

	// ---------------- stage 1: capture box, plane set ----------------
	logic                         vld_s1;
	logic                         mode_s1;
	logic signed [COORD_BITS-1:0] c_s1 [3];
	logic [HALF_W-1:0]            h_s1 [3];
	logic [LANES-1:0]             set_s1;
	logic [MASK_W-1:0]            set_in;
	logic                         take;

	assign take = start && !busy;

	always_comb begin
		set_in = plane_mask & enable_q;
		if (action == ACT_NEAR) set_in[0] = 1'b1;
	end

	// ---------------- stage 2..5 declarations ----------------
	logic                     vld_s2, vld_s3, vld_s4, vld_s5;
	logic                     mode_s2, mode_s3, mode_s4;
	logic [LANES-1:0]         set_s2, set_s3, set_s4;
	logic signed [PROD_W-1:0] dotp_s2  [LANES][3];
	logic [APRD_W-1:0]        adotp_s2 [LANES][3];
	logic signed [CMP_W-1:0]  dist_s3  [LANES];
	logic [EXT_W-1:0]         ext_s3   [LANES];
	logic [LANES-1:0]         behind_s4, cross_s4;
	logic [NEAR_W-1:0]        near_s4;
	logic                     vis_s5;
	logic [MASK_W-1:0]        strad_s5;
	logic [NEAR_W-1:0]        near_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= action;
			c_s1[0] <= center_x;
			c_s1[1] <= center_y;
			c_s1[2] <= center_z;
			h_s1[0] <= half_x;
			h_s1[1] <= half_y;
			h_s1[2] <= half_z;
			set_s1  <= set_in[LANES-1:0];
		end
		mode_s2 <= mode_s1;
		mode_s3 <= mode_s2;
		mode_s4 <= mode_s3;
		set_s2  <= set_s1;
		set_s3  <= set_s2;
		set_s4  <= set_s3;
	end

	// ---------------- per-plane lanes ----------------
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic signed [NORM_W-1:0] nrm  [3];
		logic [NORM_W-1:0]        nabs [3];
		logic signed [NORM_W-1:0] offs;
		logic signed [DOT_W-1:0]  dot;
		logic [ADOT_W-1:0]        adot;
		logic signed [SDOT_W-1:0] sdot;
		logic signed [CMP_W-1:0]  ext_c;
		logic signed [CMP_W-1:0]  diff;

		for (genvar k = 0; k < 3; k++) begin : g_axis
			assign nrm[k]  = $signed(plane_q[i][NORM_W*k +: NORM_W]);
			assign nabs[k] = nrm[k][NORM_W-1] ? NORM_W'(-nrm[k]) : NORM_W'(nrm[k]);
		end
		assign offs = $signed(plane_q[i][CFG_DATA_W-1 -: NORM_W]);

		// stage 2: products
		always_ff @(posedge clk) begin
			for (int k = 0; k < 3; k++) begin
				dotp_s2[i][k]  <= PROD_W'(nrm[k] * c_s1[k]);
				adotp_s2[i][k] <= APRD_W'(nabs[k] * h_s1[k]);
			end
		end

		// stage 3: sums, floor shift, offset
		assign dot  = DOT_W'(dotp_s2[i][0]) + DOT_W'(dotp_s2[i][1])
			+ DOT_W'(dotp_s2[i][2]);
		assign adot = ADOT_W'(adotp_s2[i][0]) + ADOT_W'(adotp_s2[i][1])
			+ ADOT_W'(adotp_s2[i][2]);
		assign sdot = dot[DOT_W-1:FRAC_BITS];  // arithmetic shift == floor

		always_ff @(posedge clk) begin
			dist_s3[i] <= CMP_W'(sdot) + CMP_W'(offs);
			ext_s3[i]  <= adot[ADOT_W-1:FRAC_BITS];
		end

		// stage 4: compares
		assign ext_c = $signed(CMP_W'(ext_s3[i]));
		assign diff  = dist_s3[i] - ext_c;

		always_ff @(posedge clk) begin
			behind_s4[i] <= (dist_s3[i] + ext_c) < $signed(CMP_W'(0));
			cross_s4[i]  <= dist_s3[i] < ext_c;
		end

		if (i == 0) begin : g_near
			always_ff @(posedge clk) begin
				if (diff < $signed(CMP_W'(0))) begin
					near_s4 <= '0;
				end else if (diff > $signed(CMP_W'(NEAR_MAX))) begin
					near_s4 <= NEAR_W'(NEAR_MAX);
				end else begin
					near_s4 <= diff[NEAR_W-1:0];
				end
			end
		end
	end

	// ---------------- stage 5: reduce to result beat ----------------
	logic vis_c;
	assign vis_c = ~|(behind_s4 & set_s4);

	always_ff @(posedge clk) begin
		vis_s5   <= vis_c;
		strad_s5 <= (vis_c && mode_s4 == ACT_STRADDLE) ? MASK_W'(cross_s4 & set_s4) : '0;
		near_s5  <= (vis_c && mode_s4 == ACT_NEAR) ? near_s4 : '0;
	end

	assign done          = vld_s5;
	assign visible       = vis_s5;
	assign straddle_mask = strad_s5;
	assign near_distance = near_s5;

	// ---------------- assertions ----------------
	a_hidden_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && !visible |-> straddle_mask == '0 && near_distance == '0)
		else $error("culled box reports mask or distance");

	a_modes_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done && straddle_mask != '0 |-> near_distance == '0)
		else $error("straddle mask and near distance both set");

	a_mask_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |=> (straddle_mask & ~MASK_W'($past(set_s4))) == '0)
		else $error("straddle bit outside tested plane set");

	a_near_tested: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && mode_s1 == ACT_NEAR |-> set_s1[0])
		else $error("near mode without near plane");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> ##2 done)
		else $error("beat lost in pipeline");

endmodule
